// ===== rtl/heater_rate_output_scaler_macros.svh =====
// ---------------------------------------------------------------------------
// Heater rate output scaler assertion macros
// Each macro expands to one labeled concurrent assertion that is
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef HEATER_RATE_OUTPUT_SCALER_MACROS_SVH
`define HEATER_RATE_OUTPUT_SCALER_MACROS_SVH

// Same-cycle implication: when the condition holds, the consequence holds too.
`define HROS_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when the condition holds, the consequence holds in the following cycle.
`define HROS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/hros_pkg.sv =====
// ---------------------------------------------------------------------------
// Heater rate output scaler package
// Shared types, constants and register indexes for the heater rate tracker.
// ---------------------------------------------------------------------------
package hros_pkg;

    // Number of tracked heaters.
    localparam int HEATERS = 4;
    localparam int HIDX_W  = (HEATERS > 1) ? $clog2(HEATERS) : 1;
    localparam int HEXT_W  = (HIDX_W > 2) ? HIDX_W : 2;

    // Command codes.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_CALC   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_STEP_THRESHOLD    = 3'd0;
    localparam logic [2:0] CFG_SETTLE_SECONDS    = 3'd1;
    localparam logic [2:0] CFG_MIN_EXTRA_SECONDS = 3'd2;
    localparam logic [2:0] CFG_MAX_FACTOR        = 3'd3;
    localparam logic [2:0] CFG_SAMPLE_PERIOD_MS  = 3'd4;

    // Configuration reset values.
    localparam logic [9:0]  STEP_THRESHOLD_RST    = 10'd48;
    localparam logic [7:0]  SETTLE_SECONDS_RST    = 8'd10;
    localparam logic [7:0]  MIN_EXTRA_SECONDS_RST = 8'd10;
    localparam logic [15:0] MAX_FACTOR_RST        = 16'd19275;
    localparam logic [15:0] SAMPLE_PERIOD_MS_RST  = 16'd1000;

    // Divider sizing: numerator is threshold * seconds * 2^14.
    localparam int PROD_W    = 26;
    localparam int FRAC_W    = 14;
    localparam int NUM_W     = PROD_W + FRAC_W;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Request payload.
    typedef struct packed {
        logic [1:0]  command;
        logic [1:0]  heater;
        logic [12:0] temperature;
        logic [31:0] now_ms;
    } cmd_t;

    // Result payload.
    typedef struct packed {
        logic        sample_taken;
        logic        calc_ok;
        logic        factor_valid;
        logic [15:0] factor;
    } res_t;

    // Per-heater state record held in the state memory.
    typedef struct packed {
        logic [31:0]        next_due_time;
        logic [12:0]        previous_temperature;
        logic [15:0]        second_count;
        logic signed [31:0] rise_sum;
        logic               large_step_seen;
        logic [12:0]        largest_step;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

endpackage

// ===== rtl/hros_ram.sv =====
// ---------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module hros_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/heater_rate_output_scaler.sv =====
// ---------------------------------------------------------------------------
// Heater rate output scaler
// Tracks per-heater heating rate and turns it into a Q2.14 output factor.
// ---------------------------------------------------------------------------
//  Channel   Signals                              Moves
//  cmd       cmd_valid / cmd_ready / cmd_data     one request (sample, calc, clear)
//  res       res_valid / res_ready / res_data     one result per request
//  cfg       cfg_write / cfg_index / cfg_data     register write, no wait
//
//  A sample, clear or unused request moves from acceptance to the result register
//  through accept and memory read, execute and write back, and result load.
//  A calculate request that produces a factor also passes through an optional multiply
//  step and the 40-step restoring divider, one quotient bit per cycle, before the result load.
//  One request is in flight at a time; the next is taken while a result waits.
//  Reset clears all heater records through per-entry valid bits.
//  A stalled result holds the core in its last state until res_ready frees it.
`include "heater_rate_output_scaler_macros.svh"

module heater_rate_output_scaler (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  hros_pkg::cmd_t cmd_data,
    output logic           res_valid,
    input  logic           res_ready,
    output hros_pkg::res_t res_data,
    input  logic           cfg_write,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    import hros_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIN  = 6'b010000,
        S_EMIT = 6'b100000
    } state_t;

    // Configuration registers.
    logic [9:0]  step_threshold_reg;
    logic [7:0]  settle_seconds_reg;
    logic [7:0]  min_extra_seconds_reg;
    logic [15:0] max_factor_reg;
    logic [15:0] sample_period_ms_reg;

    // Control and datapath registers.
    state_t              state_reg, state_next;
    cmd_t                req_reg, req_next;
    logic [HIDX_W-1:0]   idx_reg, idx_next;
    logic                range_reg, range_next;
    logic                hit_reg, hit_next;
    res_t                res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_data_reg, res_data_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [31:0]         rem_reg, rem_next;
    logic [31:0]         div_reg, div_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                sat_reg, sat_next;
    logic [HEATERS-1:0]  entry_valid_reg, entry_valid_next;

    // Memory port signals.
    logic                ram_we;
    logic                ram_re;
    logic [REC_W-1:0]    ram_wdata;
    logic [REC_W-1:0]    ram_rdata;
    logic [HIDX_W-1:0]   ram_raddr;

    // Request decode helpers.
    logic [HEXT_W-1:0]   heater_ext;
    logic                in_range;

    // Execute-stage values.
    rec_t                rec;
    rec_t                sample_rec;
    logic signed [13:0]  delta;
    logic signed [13:0]  thr_s;
    logic                delta_lt;
    logic                delta_pos;
    logic                settled;
    logic signed [32:0]  sum_ext;
    logic signed [31:0]  sum_sat;
    logic                gate_ok;
    logic                enough;
    logic [15:0]         secs;
    logic                large_ok;
    logic                avg_ok;

    // Divider step values.
    logic [32:0]         rem_shift;
    logic [32:0]         rem_diff;

    // State memory: one record per heater.
    hros_ram #(
        .WIDTH (REC_W),
        .DEPTH (HEATERS),
        .AW    (HIDX_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Heater index and range check of the incoming request.
    assign heater_ext = HEXT_W'(cmd_data.heater);
    assign ram_raddr  = heater_ext[HIDX_W-1:0];
    assign in_range   = (32'(cmd_data.heater) < 32'(HEATERS));

    // An entry never written since reset reads as all zero.
    assign rec = hit_reg ? rec_t'(ram_rdata) : rec_t'('0);

    // Sample arithmetic on the fetched record.
    always_comb
    begin
        delta     = $signed({1'b0, req_reg.temperature}) -
                    $signed({1'b0, rec.previous_temperature});
        thr_s     = $signed({4'b0, step_threshold_reg});
        delta_lt  = (delta < thr_s);
        delta_pos = (delta > 14'sd0);
        settled   = (rec.second_count > 16'(settle_seconds_reg));
        gate_ok   = (rec.next_due_time <= req_reg.now_ms);

        sum_ext = {rec.rise_sum[31], rec.rise_sum} + {{19{delta[13]}}, delta};
        if (sum_ext[32] != sum_ext[31])
        begin
            sum_sat = sum_ext[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            sum_sat = sum_ext[31:0];
        end

        sample_rec                      = rec;
        sample_rec.previous_temperature = req_reg.temperature;
        sample_rec.next_due_time        = req_reg.now_ms + 32'(sample_period_ms_reg);
        if (rec.previous_temperature == 13'd0)
        begin
            sample_rec.rise_sum = 32'sd0;
        end
        else
        begin
            if (settled && (delta_lt || delta_pos))
            begin
                sample_rec.rise_sum = sum_sat;
            end
            if (delta_pos && (rec.second_count != 16'hFFFF))
            begin
                sample_rec.second_count = rec.second_count + 16'd1;
            end
            if (!delta_lt && delta_pos)
            begin
                sample_rec.large_step_seen = 1'b1;
                if (delta[12:0] > rec.largest_step)
                begin
                    sample_rec.largest_step = delta[12:0];
                end
            end
        end
    end

    // Calculate conditions on the fetched record.
    always_comb
    begin
        enough   = (rec.second_count >=
                    (16'(settle_seconds_reg) + 16'(min_extra_seconds_reg)));
        secs     = rec.second_count - 16'(settle_seconds_reg);
        large_ok = rec.large_step_seen && (rec.largest_step != 13'd0);
        avg_ok   = (rec.second_count != 16'd0) && !rec.rise_sum[31] &&
                   (rec.rise_sum != 32'sd0);
    end

    // Restoring divider step.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    // Sequencer: read, execute and write back, optional multiply, divide and factor finish, result load.
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        range_next       = range_reg;
        hit_next         = hit_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg;
        res_data_next    = res_data_reg;
        prod_next        = prod_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        sat_next         = sat_reg;
        entry_valid_next = entry_valid_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_wdata        = '0;
        cmd_ready        = (state_reg == S_IDLE);

        // The downstream side takes the waiting result.
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ram_re     = 1'b1;
                    req_next   = cmd_data;
                    idx_next   = ram_raddr;
                    range_next = in_range;
                    hit_next   = in_range && entry_valid_reg[ram_raddr];
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_next   = '0;
                state_next = S_EMIT;
                if (range_reg)
                begin
                    case (req_reg.command)
                        CMD_SAMPLE:
                        begin
                            if (gate_ok)
                            begin
                                ram_we                = 1'b1;
                                ram_wdata             = REC_W'(sample_rec);
                                res_next.sample_taken = 1'b1;
                            end
                        end
                        CMD_CALC:
                        begin
                            ram_we = 1'b1;
                            if (enough)
                            begin
                                res_next.calc_ok = 1'b1;
                                if (large_ok)
                                begin
                                    quo_next   = NUM_W'(step_threshold_reg) << FRAC_W;
                                    rem_next   = '0;
                                    div_next   = 32'(rec.largest_step);
                                    cnt_next   = CNT_W'(DIV_STEPS - 1);
                                    sat_next   = 1'b1;
                                    state_next = S_DIV;
                                end
                                else if (avg_ok)
                                begin
                                    prod_next  = PROD_W'(step_threshold_reg) *
                                                 PROD_W'(secs);
                                    div_next   = rec.rise_sum;
                                    sat_next   = 1'b0;
                                    state_next = S_MUL;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            ram_we = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (ram_we)
                begin
                    entry_valid_next[idx_reg] = 1'b1;
                end
            end

            S_MUL:
            begin
                quo_next   = {prod_reg, {FRAC_W{1'b0}}};
                rem_next   = '0;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (!rem_diff[32])
                begin
                    rem_next = rem_diff[31:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[31:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end

            S_FIN:
            begin
                res_next.factor_valid = 1'b1;
                if (sat_reg)
                begin
                    res_next.factor = (quo_reg > NUM_W'(16'hFFFF)) ?
                                      16'hFFFF : quo_reg[15:0];
                end
                else
                begin
                    res_next.factor = (quo_reg >= NUM_W'(max_factor_reg)) ?
                                      max_factor_reg : quo_reg[15:0];
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_data_next  = res_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            res_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            res_valid_reg   <= res_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        range_reg    <= range_next;
        hit_reg      <= hit_next;
        res_reg      <= res_next;
        res_data_reg <= res_data_next;
        prod_reg     <= prod_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        cnt_reg      <= cnt_next;
        sat_reg      <= sat_next;
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_threshold_reg    <= STEP_THRESHOLD_RST;
            settle_seconds_reg    <= SETTLE_SECONDS_RST;
            min_extra_seconds_reg <= MIN_EXTRA_SECONDS_RST;
            max_factor_reg        <= MAX_FACTOR_RST;
            sample_period_ms_reg  <= SAMPLE_PERIOD_MS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_STEP_THRESHOLD:    step_threshold_reg    <= cfg_data[9:0];
                CFG_SETTLE_SECONDS:    settle_seconds_reg    <= cfg_data[7:0];
                CFG_MIN_EXTRA_SECONDS: min_extra_seconds_reg <= cfg_data[7:0];
                CFG_MAX_FACTOR:        max_factor_reg        <= cfg_data;
                CFG_SAMPLE_PERIOD_MS:  sample_period_ms_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // Checks on sequencing, memory interlock, divider and result encoding.
    `HROS_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, cmd_valid && cmd_ready,
        state_reg == S_EXEC, "accepted request did not move to execute")
    `HROS_ASSERT_NOW(a_no_rw_overlap, clk, rst_n, ram_we, !ram_re,
        "state memory read and write in the same cycle")
    `HROS_ASSERT_NOW(a_div_rem_bound, clk, rst_n, state_reg == S_DIV,
        rem_reg < div_reg, "divider remainder not below divisor")
    `HROS_ASSERT_NOW(a_factor_zero, clk, rst_n, res_valid && !res_data.factor_valid,
        res_data.factor == 16'd0, "factor nonzero without factor_valid")

endmodule
